// ----- src/egp_pkg.sv -----
package egp_pkg;

   // text byte codes
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;

   localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;
   localparam logic [7:0]  LINE_HEIGHT_RESET = 8'd8;

   // tab stop spacing in pixels, a power of two
   localparam int TAB_STOP  = 32;
   localparam int TAB_SHIFT = $clog2(TAB_STOP);

   // register indexes on the csr port
   localparam logic CSR_LINE_HEIGHT = 1'b0;

   // escape phase codes
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_DOLLAR  = 3'd1;
   localparam logic [2:0] PH_DIGITS1 = 3'd2;
   localparam logic [2:0] PH_DIGITS5 = 3'd6;

   typedef struct packed {
      logic              mode;
      logic [7:0]        char_byte;
      logic [7:0]        glyph_width;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
   } item_type;

   typedef struct packed {
      logic [7:0]         glyph_code;
      logic signed [15:0] pen_x;
      logic signed [15:0] pen_y;
      logic [23:0]        color_rgb;
   } result_type;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 4'(c - 8'h57);
      end
      return v;
   endfunction

endpackage

// ----- src/egp_csr.sv -----
module egp_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [7:0]  line_height
);
   import egp_pkg::*;

   logic [7:0] line_height_ff;
   logic [7:0] line_height_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      line_height_in = line_height_ff;
      if (wr_en && csr_paddr[2] == CSR_LINE_HEIGHT) begin
         line_height_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_height_ff <= LINE_HEIGHT_RESET;
      end else begin
         line_height_ff <= line_height_in;
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == CSR_LINE_HEIGHT) begin
         csr_prdata = {24'd0, line_height_ff};
      end
   end

   assign line_height = line_height_ff;

endmodule

// ----- src/egp_engine.sv -----
module egp_engine #(
   parameter int COORD_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  egp_pkg::item_type   item,
   input  logic [7:0]          line_height,
   output logic                has_result,
   output egp_pkg::result_type result
);
   import egp_pkg::*;

   logic [2:0]            phase_ff, phase_in, phase_cur;
   logic [23:0]           build_ff, build_in;
   logic [23:0]           color_ff, color_in;
   logic [COORD_BITS-1:0] pen_x_ff, pen_x_in;
   logic [COORD_BITS-1:0] pen_y_ff, pen_y_in;
   logic [COORD_BITS-1:0] start_x_ff, start_x_in;

   logic signed [31:0]    org_x_ext, org_y_ext;
   logic [31:0]           width_ext, height_ext;
   logic [31:0]           pen_x_zext, pen_y_zext;
   logic signed [32:0]    tab_sum, tab_round;
   logic [3:0]            digit;

   // operand extensions to 32 bits
   assign org_x_ext  = 32'(item.origin_x);
   assign org_y_ext  = 32'(item.origin_y);
   assign width_ext  = 32'(item.glyph_width);
   assign height_ext = 32'(line_height);
   assign pen_x_zext = 32'(pen_x_ff);
   assign pen_y_zext = 32'(pen_y_ff);
   assign digit      = hex_value(item.char_byte);

   // next tab stop, quotient truncated toward zero
   always_comb begin
      tab_sum   = 33'(signed'(pen_x_ff)) + 33'(TAB_STOP);
      tab_round = {tab_sum[32:TAB_SHIFT], {TAB_SHIFT{1'b0}}};
      if (tab_sum[32] && (|tab_sum[TAB_SHIFT-1:0])) begin
         tab_round = tab_round + 33'(TAB_STOP);
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      build_in   = build_ff;
      color_in   = color_ff;
      pen_x_in   = pen_x_ff;
      pen_y_in   = pen_y_ff;
      start_x_in = start_x_ff;
      has_result = 1'b0;
      result.glyph_code = item.char_byte;
      result.pen_x      = pen_x_zext[15:0];
      result.pen_y      = pen_y_zext[15:0];
      result.color_rgb  = color_ff;
      phase_cur = (phase_ff > PH_DIGITS5) ? PH_IDLE : phase_ff;

      if (!item.mode) begin
         pen_x_in   = org_x_ext[COORD_BITS-1:0];
         pen_y_in   = org_y_ext[COORD_BITS-1:0];
         start_x_in = org_x_ext[COORD_BITS-1:0];
         color_in   = COLOR_WHITE;
         phase_in   = PH_IDLE;
         build_in   = 24'd0;
      end else begin
         priority if (phase_cur == PH_DOLLAR && item.char_byte != CH_DOLLAR) begin
            build_in = {20'd0, digit};
            phase_in = PH_DIGITS1;
         end else if (phase_cur >= PH_DIGITS1) begin
            build_in = {build_ff[19:0], digit};
            if (phase_cur == PH_DIGITS5) begin
               color_in = build_in;
               phase_in = PH_IDLE;
            end else begin
               phase_in = phase_cur + 3'd1;
            end
         end else if (phase_cur == PH_IDLE && item.char_byte == CH_DOLLAR) begin
            phase_in = PH_DOLLAR;
         end else begin
            phase_in = PH_IDLE;
            unique case (item.char_byte)
               CH_NEWLINE: begin
                  pen_x_in = start_x_ff;
                  pen_y_in = pen_y_ff + height_ext[COORD_BITS-1:0];
               end
               CH_SPACE: begin
                  pen_x_in = pen_x_ff + width_ext[COORD_BITS-1:0];
               end
               CH_TAB: begin
                  pen_x_in = tab_round[COORD_BITS-1:0];
               end
               default: begin
                  has_result = 1'b1;
                  pen_x_in   = pen_x_ff + width_ext[COORD_BITS-1:0];
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         build_ff   <= 24'd0;
         color_ff   <= COLOR_WHITE;
         pen_x_ff   <= '0;
         pen_y_ff   <= '0;
         start_x_ff <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         build_ff   <= build_in;
         color_ff   <= color_in;
         pen_x_ff   <= pen_x_in;
         pen_y_ff   <= pen_y_in;
         start_x_ff <= start_x_in;
      end
   end

endmodule

// ----- src/escaped_text_glyph_placer.sv -----
// an accepted req transaction passes the input register and then the result register to become its rsp transaction
// throughput: one req transaction per cycle while a held result is not stalled by rsp_ready
// bytes that only move the pen or build a color, and mode 0 origin transactions, give no rsp transaction
// reset (synchronous, active high): pen and line origin at 0, color white,
// no escape pending, line_height 8, both pipeline registers empty
module escaped_text_glyph_placer #(
   parameter int COORD_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [7:0]         req_char_byte,
   input  logic [7:0]         req_glyph_width,
   input  logic signed [15:0] req_origin_x,
   input  logic signed [15:0] req_origin_y,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_glyph_code,
   output logic signed [15:0] rsp_pen_x,
   output logic signed [15:0] rsp_pen_y,
   output logic [23:0]        rsp_color_rgb,

   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import egp_pkg::*;

   // input register stage
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;

   // result register stage
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;

   logic       fire;
   logic       has_result;
   result_type step_res;
   logic [7:0] line_height;

   egp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .line_height (line_height)
   );

   // the held transaction steps the pen state whenever the result register
   // is empty or being drained this cycle
   assign fire = in_valid_ff && (!out_valid_ff || rsp_ready);

   // the input register frees up in the same cycle it is consumed
   assign req_ready = !in_valid_ff || fire;

   egp_engine #(
      .COORD_BITS (COORD_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (in_item_ff),
      .line_height (line_height),
      .has_result  (has_result),
      .result      (step_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = has_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff.mode        <= req_mode;
         in_item_ff.char_byte   <= req_char_byte;
         in_item_ff.glyph_width <= req_glyph_width;
         in_item_ff.origin_x    <= req_origin_x;
         in_item_ff.origin_y    <= req_origin_y;
      end
      if (fire && has_result) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_glyph_code = out_res_ff.glyph_code;
   assign rsp_pen_x      = out_res_ff.pen_x;
   assign rsp_pen_y      = out_res_ff.pen_y;
   assign rsp_color_rgb  = out_res_ff.color_rgb;

endmodule
